// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on clk_i, held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FR_ASSERT_IMPL(lbl, ante, cons, msg)
`define FR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/frot_pkg.sv =====
// ----------------------------------------------------------------------------
// frot_pkg
// shared constants, codes and controller/datapath types of the frame rotator
// ----------------------------------------------------------------------------
`default_nettype none

package frot_pkg;

  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DIM_W       = 9;
  localparam int unsigned COORD_W     = $clog2(MAX_DIM);
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned DIV_CNT_W   = $clog2(CNT_W);
  localparam int unsigned PIX_W       = 32;
  localparam int unsigned HALF_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 9;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_FETCH = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [1:0] {
    FMT_WORD32 = 2'd0,
    FMT_WORD16 = 2'd1,
    FMT_YCC    = 2'd2
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_ROTATION = 2'd2,
    CFG_FORMAT   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_RD_PIX,
    ST_RD_NB,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic fetch_start;
    logic div_start;
    logic div_load;
    logic addr_calc;
    logic rd_pix;
    logic rd_nb;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic frame_full;
    logic wrap;
    logic dirty;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/frot_if.sv =====
// ----------------------------------------------------------------------------
// frot_if
// valid/ready channels of the frame rotator: input beat and result beat
// ----------------------------------------------------------------------------
`default_nettype none

interface frot_in_if import frot_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface frot_out_if import frot_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             end_of_row;
  logic             end_of_frame;
  logic             not_ready;

  modport source (output valid, output pixel_out, output end_of_row, output end_of_frame,
                  output not_ready, input ready);
  modport sink   (input valid, input pixel_out, input end_of_row, input end_of_frame,
                  input not_ready, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/frot_ram.sv =====
// ----------------------------------------------------------------------------
// frot_ram
// generic single-port ram, one access per cycle, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module frot_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/frot_div.sv =====
// ----------------------------------------------------------------------------
// frot_div
// restoring divider, one quotient bit per cycle, splits the output count
// into column and row of the rotated frame
// ----------------------------------------------------------------------------
`default_nettype none

module frot_div import frot_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CNT_W-1:0]   dividend_i,
  input  logic [DIM_W-1:0]   divisor_i,
  output logic               done_o,
  output logic [COORD_W-1:0] quotient_o,
  output logic [COORD_W-1:0] remainder_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]     quo_q, quo_d;
  logic [COORD_W-1:0]   rem_q, rem_d;
  logic [COORD_W:0]     trial;
  logic                 ge;

  always_comb begin
    trial  = {rem_q, quo_q[CNT_W-1]};
    ge     = ({1'b0, trial} >= {1'b0, divisor_i});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(CNT_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[CNT_W-2:0], ge};
      rem_d = ge ? COORD_W'(trial - (COORD_W+1)'(divisor_i)) : COORD_W'(trial);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q[COORD_W-1:0];
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/frot_dp.sv =====
// ----------------------------------------------------------------------------
// frot_dp
// datapath: configuration registers, counters, address generation, frame
// store, chroma merge and result register
// ----------------------------------------------------------------------------
`default_nettype none

module frot_dp import frot_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PIX_W-1:0]      pixel_in_i,
  input  logic                  out_ready_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic                  end_of_row_o,
  output logic                  end_of_frame_o,
  output logic                  not_ready_o
);

  // configuration
  logic [DIM_W-1:0] width_q, height_q;
  rot_e             rot_q;
  logic [1:0]       fmt_q;

  // control state
  logic [CNT_W-1:0]   load_cnt_q, emit_cnt_q;
  logic [COORD_W-1:0] ox_q, oy_q;
  logic               dirty_q, nr_q, out_valid_q;

  // payload
  logic [ADDR_W-1:0]  base_q;
  logic [COORD_W-1:0] x_q, nx_q;
  logic               take_nb_q;
  logic [PIX_W-1:0]   pix_q;
  logic [PIX_W-1:0]   res_pix_q;
  logic               res_eor_q, res_eof_q, res_nr_q;

  logic [DIM_W-1:0]   w_eff, h_eff, ow;
  logic [COORD_W-1:0] w_m1, h_m1;
  logic [CNT_W-1:0]   total;
  logic               frame_full, wrap, is16, ycc_fix;

  logic [COORD_W-1:0] x_c, y_c, nx_c;
  logic [COORD_W:0]   nx_wide;
  logic               take_nb_c;
  logic [CNT_W-1:0]   prod_c;

  logic               ram_en, ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [PIX_W-1:0]   ram_wdata, ram_rdata;

  logic               div_done;
  logic [COORD_W-1:0] div_quo, div_rem;

  logic [PIX_W-1:0]   c1, res_pix;
  logic               eor, eof, out_free;

  // effective sizes
  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_q > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    w_m1       = COORD_W'(w_eff - 1'b1);
    h_m1       = COORD_W'(h_eff - 1'b1);
    ow         = (rot_q == ROT_90 || rot_q == ROT_270) ? h_eff : w_eff;
    total      = CNT_W'(w_eff) * CNT_W'(h_eff);
    frame_full = (load_cnt_q >= total);
    wrap       = (emit_cnt_q >= total);
    is16       = (fmt_q == FMT_WORD16) || (fmt_q == FMT_YCC);
    ycc_fix    = (fmt_q == FMT_YCC) && (rot_q != ROT_0);
  end

  // source coordinates of the current output pixel
  always_comb begin
    case (rot_q)
      ROT_90: begin
        x_c = oy_q;
        y_c = h_m1 - ox_q;
      end
      ROT_180: begin
        x_c = w_m1 - ox_q;
        y_c = h_m1 - oy_q;
      end
      ROT_270: begin
        x_c = w_m1 - oy_q;
        y_c = ox_q;
      end
      default: begin
        x_c = ox_q;
        y_c = oy_q;
      end
    endcase
    if (rot_q == ROT_180 && x_c[0]) begin
      nx_wide = {1'b0, x_c} - 1'b1;
    end else begin
      nx_wide = {1'b0, x_c} + 1'b1;
    end
    nx_c      = (nx_wide > {1'b0, w_m1}) ? w_m1 : nx_wide[COORD_W-1:0];
    take_nb_c = ycc_fix && ((rot_q == ROT_180) ||
                            (rot_q == ROT_90  && !(x_c[0] ^ y_c[0])) ||
                            (rot_q == ROT_270 &&  (x_c[0] ^ y_c[0])));
    prod_c    = CNT_W'(y_c) * CNT_W'(w_eff);
  end

  // frame store port
  always_comb begin
    ram_we    = cmd_i.load && !frame_full;
    ram_en    = ram_we || cmd_i.rd_pix || cmd_i.rd_nb;
    ram_wdata = is16 ? {{(PIX_W-HALF_W){1'b0}}, pixel_in_i[HALF_W-1:0]} : pixel_in_i;
    if (cmd_i.rd_pix) begin
      ram_addr = base_q + ADDR_W'(x_q);
    end else if (cmd_i.rd_nb) begin
      ram_addr = base_q + ADDR_W'(nx_q);
    end else begin
      ram_addr = load_cnt_q[ADDR_W-1:0];
    end
  end

  frot_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  frot_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (emit_cnt_q),
    .divisor_i   (ow),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // result of the current fetch
  always_comb begin
    c1 = take_nb_q ? ram_rdata : pix_q;
    if (ycc_fix) begin
      res_pix = {{(PIX_W-HALF_W){1'b0}}, c1[HALF_W-1:BYTE_W], pix_q[BYTE_W-1:0]};
    end else if (is16) begin
      res_pix = {{(PIX_W-HALF_W){1'b0}}, pix_q[HALF_W-1:0]};
    end else begin
      res_pix = pix_q;
    end
    eor      = (({1'b0, ox_q} + 1'b1) == ow);
    eof      = ((emit_cnt_q + CNT_W'(1)) == total);
    out_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(MAX_WIDTH);
      height_q <= DIM_W'(MAX_HEIGHT);
      rot_q    <= ROT_0;
      fmt_q    <= FMT_WORD32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:    width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:   height_q <= cfg_data_i[DIM_W-1:0];
        CFG_ROTATION: rot_q    <= rot_e'(cfg_data_i[1:0]);
        CFG_FORMAT:   fmt_q    <= cfg_data_i[1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      emit_cnt_q  <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      dirty_q     <= 1'b0;
      nr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dirty_q <= 1'b1;
      end
      if (ram_we) begin
        load_cnt_q <= load_cnt_q + 1'b1;
      end
      if (cmd_i.fetch_start) begin
        nr_q <= !frame_full;
        if (frame_full && wrap) begin
          emit_cnt_q <= '0;
          ox_q       <= '0;
          oy_q       <= '0;
          dirty_q    <= 1'b0;
        end
      end
      if (cmd_i.div_load) begin
        ox_q    <= div_rem;
        oy_q    <= div_quo;
        dirty_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (!nr_q) begin
          if (eof) begin
            emit_cnt_q <= '0;
            load_cnt_q <= '0;
            ox_q       <= '0;
            oy_q       <= '0;
          end else begin
            emit_cnt_q <= emit_cnt_q + 1'b1;
            if (eor) begin
              ox_q <= '0;
              oy_q <= oy_q + 1'b1;
            end else begin
              ox_q <= ox_q + 1'b1;
            end
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_calc) begin
      base_q    <= prod_c[ADDR_W-1:0];
      x_q       <= x_c;
      nx_q      <= nx_c;
      take_nb_q <= take_nb_c;
    end
    if (cmd_i.rd_nb) begin
      pix_q <= ram_rdata;
    end
    if (cmd_i.emit) begin
      res_pix_q <= nr_q ? '0 : res_pix;
      res_eor_q <= !nr_q && eor;
      res_eof_q <= !nr_q && eof;
      res_nr_q  <= nr_q;
    end
  end

  assign sts_o.frame_full = frame_full;
  assign sts_o.wrap       = wrap;
  assign sts_o.dirty      = dirty_q;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = out_free;

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = res_pix_q;
  assign end_of_row_o   = res_eor_q;
  assign end_of_frame_o = res_eof_q;
  assign not_ready_o    = res_nr_q;

endmodule

`default_nettype wire

// ===== rtl/core/frot_ctrl.sv =====
// ----------------------------------------------------------------------------
// frot_ctrl
// controller: accepts beats and sequences each fetch through the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module frot_ctrl import frot_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  action_e in_action_i,
  output logic    in_ready_o,
  input  sts_t    sts_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept, fetch;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign fetch  = accept && (in_action_i == ACT_FETCH);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fetch) begin
          if (!sts_i.frame_full) begin
            state_d = ST_DONE;
          end else if (sts_i.wrap || !sts_i.dirty) begin
            state_d = ST_ADDR;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR:   state_d = ST_RD_PIX;
      ST_RD_PIX: state_d = ST_RD_NB;
      ST_RD_NB:  state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    cmd_o             = '0;
    cmd_o.load        = accept && (in_action_i == ACT_LOAD);
    cmd_o.fetch_start = fetch;
    cmd_o.div_start   = fetch && sts_i.frame_full && !sts_i.wrap && sts_i.dirty;
    cmd_o.div_load    = (state_q == ST_DIV) && sts_i.div_done;
    cmd_o.addr_calc   = (state_q == ST_ADDR);
    cmd_o.rd_pix      = (state_q == ST_RD_PIX);
    cmd_o.rd_nb       = (state_q == ST_RD_NB);
    cmd_o.emit        = (state_q == ST_DONE) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/frame_rotator_90_180_270.sv =====
// ----------------------------------------------------------------------------
// frame_rotator_90_180_270
// rotates a stored frame by 0, 90, 180 or 270 degrees, with chroma fix for
// ycbycr pixels
// ----------------------------------------------------------------------------
// in_i carries load beats (action 0, pixel_in written in raster order) and
// fetch beats (action 1); out_o returns one result beat per fetch, the
// rotated frame in its own raster order with end-of-row and end-of-frame.
// a fetch before the frame is complete returns not_ready with zero data.
// loads are taken one per cycle while idle. a fetch of a complete frame runs
// in steps set by the single-port frame store: the address multiply, two
// reads (pixel and chroma neighbour), then a merge into the result register;
// no beat is taken until it is through. the first fetch of a complete frame
// after a configuration write first waits while the serial divider
// recomputes the output row and column, unless the output count has wrapped.
// the result register decouples the sides: the next beat is taken while a
// result waits; a fetch holds in its last step while out_o stalls.
// reset clears counters and sets 256 x 256, no rotation, 32-bit words; the
// frame store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module frame_rotator_90_180_270 import frot_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  frot_in_if.sink               in_i,
  frot_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  frot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (action_e'(in_i.action)),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  frot_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_in_i     (in_i.pixel_in),
    .out_ready_i    (out_o.ready),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_o.valid),
    .pixel_out_o    (out_o.pixel_out),
    .end_of_row_o   (out_o.end_of_row),
    .end_of_frame_o (out_o.end_of_frame),
    .not_ready_o    (out_o.not_ready)
  );

  assign in_i.ready = in_ready;

  `FR_ASSERT_NEXT(a_fetch_busy, in_i.valid && in_i.ready && in_i.action, !in_i.ready, "fetch beat did not make the block busy")
  `FR_ASSERT_IMPL(a_eof_eor, out_o.valid && out_o.end_of_frame, out_o.end_of_row, "end of frame without end of row")
  `FR_ASSERT_IMPL(a_nr_clean, out_o.valid && out_o.not_ready, out_o.pixel_out == '0 && !out_o.end_of_row && !out_o.end_of_frame, "not ready beat carries data")

endmodule

`default_nettype wire
